// ===== rtl/core/bdslp_pkg.sv =====
// Package for the button debounce / press classifier.
// Register indexes, reset values, field widths and the result beat type.
// No dependencies.
`timescale 1ns / 1ps

package bdslp_pkg;

	// configuration register map
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;

	// register widths and reset values
	localparam int DEBOUNCE_W   = 10;
	localparam int LONG_PRESS_W = 16;
	localparam logic [DEBOUNCE_W-1:0]   DEBOUNCE_RST   = 10'd50;
	localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_RST = 16'd800;

	// default counter width
	localparam int COUNT_WIDTH_DEF = 16;

	// one result beat
	typedef struct packed {
		logic stable_pressed;
		logic short_press;
		logic long_press;
	} result_t;

endpackage

// ===== rtl/core/button_debounce_short_long_press_core.sv =====
// Top level of the button debounce core; uses bdslp_pkg for constants and types.
// A result beat is registered into the main output register, or into skid while main
// holds an untaken beat. Throughput: one tick beat per cycle while in_stall is low;
// per-tick work is two counter increments and two compares between the state registers
// and the output register. Main + skid output stage keeps ticks flowing while a result
// waits. Reset (arst_n, async, low): released, counters zero, config 50 / 800 ticks, output stage empty.
`timescale 1ns / 1ps

module button_debounce_short_long_press_core #(
	parameter int COUNT_WIDTH = bdslp_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,

	// tick channel
	input  logic in_valid,
	output logic in_stall,
	input  logic pin_level,

	// result channel
	output logic out_valid,
	input  logic out_stall,
	output logic stable_pressed,
	output logic short_press,
	output logic long_press,

	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bdslp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bdslp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// compare width wide enough for both the hold counter and the hold register
	localparam int CMP_W = (COUNT_WIDTH > bdslp_pkg::LONG_PRESS_W) ?
		COUNT_WIDTH : bdslp_pkg::LONG_PRESS_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	// ---------------- configuration ----------------
	logic [bdslp_pkg::DEBOUNCE_W-1:0]   debounce_q;
	logic [bdslp_pkg::LONG_PRESS_W-1:0] long_press_q;

	// writes only land while idle is a rule for the user; the block does not enforce it, and the port can always take them
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= bdslp_pkg::DEBOUNCE_RST;
			long_press_q <= bdslp_pkg::LONG_PRESS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bdslp_pkg::REG_DEBOUNCE: begin
					debounce_q <= cfg_data[bdslp_pkg::DEBOUNCE_W-1:0];
				end
				bdslp_pkg::REG_LONG_PRESS: begin
					long_press_q <= cfg_data[bdslp_pkg::LONG_PRESS_W-1:0];
				end
				default: begin
					// unmapped index: write dropped
				end
			endcase
		end
	end

	// ---------------- debounce / press state ----------------
	logic                   raw_last_q;
	logic                   stable_q;
	logic [COUNT_WIDTH-1:0] steady_q;
	logic [COUNT_WIDTH-1:0] hold_q;
	logic                   long_rep_q;

	logic                   in_acc;
	logic                   raw;
	logic [COUNT_WIDTH-1:0] steady_nx;
	logic                   stable_nx;
	logic                   press_start;
	logic [COUNT_WIDTH-1:0] hold_nx;
	logic                   long_rep_base;
	logic                   long_ev;
	logic                   short_ev;
	logic                   long_rep_nx;
	bdslp_pkg::result_t     res_nx;

	assign in_acc = in_valid && !in_stall;
	assign raw    = ~pin_level;  // active-low pin

	always_comb begin
		// steady counter restarts on any raw edge, else saturating count
		if (raw != raw_last_q) begin
			steady_nx = '0;
		end else if (steady_q == CNT_MAX) begin
			steady_nx = steady_q;
		end else begin
			steady_nx = steady_q + COUNT_WIDTH'(1);
		end

		// stable state follows the raw level once steady long enough
		if (steady_nx >= COUNT_WIDTH'(debounce_q)) begin
			stable_nx = raw;
		end else begin
			stable_nx = stable_q;
		end

		press_start = !stable_q && stable_nx;

		// hold counter: zero at press start, counts while pressed, holds while released
		if (press_start) begin
			hold_nx = '0;
		end else if (stable_nx && (hold_q != CNT_MAX)) begin
			hold_nx = hold_q + COUNT_WIDTH'(1);
		end else begin
			hold_nx = hold_q;
		end

		long_rep_base = press_start ? 1'b0 : long_rep_q;
		long_ev = stable_nx && !long_rep_base &&
			(CMP_W'(hold_nx) >= CMP_W'(long_press_q));
		long_rep_nx = long_rep_base || long_ev;
		short_ev = stable_q && !stable_nx && !long_rep_base;

		res_nx.stable_pressed = stable_nx;
		res_nx.short_press    = short_ev;
		res_nx.long_press     = long_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_last_q <= 1'b0;
			stable_q   <= 1'b0;
			steady_q   <= '0;
			hold_q     <= '0;
			long_rep_q <= 1'b0;
		end else if (in_acc) begin
			raw_last_q <= raw;
			stable_q   <= stable_nx;
			steady_q   <= steady_nx;
			hold_q     <= hold_nx;
			long_rep_q <= long_rep_nx;
		end
	end

	// ---------------- output stage: main register plus skid ----------------
	bdslp_pkg::result_t main_q;
	bdslp_pkg::result_t skid_q;
	logic               main_vld_q;
	logic               skid_vld_q;
	logic               out_take;

	assign out_take  = main_vld_q && !out_stall;
	// stall comes straight from a register; skid full means both slots taken
	assign in_stall  = skid_vld_q;
	assign out_valid = main_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_vld_q) begin
				// no new beat possible; drain skid into main when taken
				if (out_take) begin
					skid_vld_q <= 1'b0;
				end
			end else if (in_acc) begin
				if (main_vld_q && !out_take) begin
					skid_vld_q <= 1'b1;
				end else begin
					main_vld_q <= 1'b1;
				end
			end else if (out_take) begin
				main_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_take) begin
				main_q <= skid_q;
			end
		end else if (in_acc) begin
			if (main_vld_q && !out_take) begin
				skid_q <= res_nx;
			end else begin
				main_q <= res_nx;
			end
		end
	end

	assign stable_pressed = main_q.stable_pressed;
	assign short_press    = main_q.short_press;
	assign long_press     = main_q.long_press;

endmodule

// ===== tb/button_debounce_short_long_press_core_test.sv =====
// Self-checking testbench for button_debounce_short_long_press_core.
// Holds a tick-accurate press tracker (class) plus tasks that drive ticks and register writes.
// Depends on bdslp_pkg and the core RTL only.
`timescale 1ns / 1ps

module button_debounce_short_long_press_core_test;

	localparam int CW = bdslp_pkg::COUNT_WIDTH_DEF;

	// indexes past the register map; writes there must be dropped
	localparam logic [bdslp_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [bdslp_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// Tracks the debounced button state tick by tick and queues the result
	// beat each accepted tick should produce. Counters saturate at all ones.
	class press_tracker;
		logic [bdslp_pkg::DEBOUNCE_W-1:0]   debounce_lim;
		logic [bdslp_pkg::LONG_PRESS_W-1:0] hold_lim;
		logic                               raw_last;
		logic                               stable;
		logic                               long_done;
		logic [CW-1:0]                      steady_cnt;
		logic [CW-1:0]                      hold_cnt;
		bdslp_pkg::result_t                 pending[$];
		int                                 errors;

		function new();
			debounce_lim = bdslp_pkg::DEBOUNCE_RST;
			hold_lim     = bdslp_pkg::LONG_PRESS_RST;
			raw_last     = 1'b0;
			stable       = 1'b0;
			long_done    = 1'b0;
			steady_cnt   = '0;
			hold_cnt     = '0;
			errors       = 0;
		endfunction

		function void write_reg(logic [bdslp_pkg::CFG_IDX_W-1:0] idx,
				logic [bdslp_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				bdslp_pkg::REG_DEBOUNCE: begin
					debounce_lim = data[bdslp_pkg::DEBOUNCE_W-1:0];
				end
				bdslp_pkg::REG_LONG_PRESS: begin
					hold_lim = data[bdslp_pkg::LONG_PRESS_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void note_tick(logic lvl);
			logic               raw;
			logic               was;
			bdslp_pkg::result_t r;
			raw = ~lvl;
			was = stable;
			r   = '0;
			if (raw != raw_last) begin
				raw_last   = raw;
				steady_cnt = '0;
			end else if (steady_cnt != '1) begin
				steady_cnt = steady_cnt + CW'(1);
			end
			if (steady_cnt >= debounce_lim && raw != stable)
				stable = raw;
			if (!was && stable) begin
				hold_cnt  = '0;
				long_done = 1'b0;
			end else if (stable && hold_cnt != '1) begin
				hold_cnt = hold_cnt + CW'(1);
			end
			if (stable && !long_done && hold_cnt >= hold_lim) begin
				r.long_press = 1'b1;
				long_done    = 1'b1;
			end
			if (was && !stable && !long_done)
				r.short_press = 1'b1;
			r.stable_pressed = stable;
			pending.push_back(r);
		endfunction

		function void check_result(bdslp_pkg::result_t got);
			bdslp_pkg::result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result beat with no tick pending: got st/sh/lg %b%b%b",
						got.stable_pressed, got.short_press, got.long_press);
			end else begin
				want = pending.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch at %0t: st/sh/lg expected %b%b%b got %b%b%b",
							$realtime, want.stable_pressed, want.short_press,
							want.long_press, got.stable_pressed, got.short_press,
							got.long_press);
				end
			end
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n    = 1'b0;
	logic                             in_valid  = 1'b0;
	logic                             in_stall;
	logic                             pin_level = 1'b1;   // released
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             stable_pressed;
	logic                             short_press;
	logic                             long_press;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [bdslp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bdslp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// gaps_on enables random idle cycles on the tick side and random stalls
	// on the result side; cleared for the quiet stretches
	bit           gaps_on = 1'b0;
	press_tracker tracker;

	button_debounce_short_long_press_core #(
		.COUNT_WIDTH(CW)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pin_level     (pin_level),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.stable_pressed(stable_pressed),
		.short_press   (short_press),
		.long_press    (long_press),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: stalls at random, about 6 percent of the time, while gaps are on
	always @(posedge clk) begin
		out_stall <= gaps_on && ($urandom_range(0, 99) < 6);
	end

	// result monitor; values read here are the ones from before the edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result({stable_pressed, short_press, long_press});
	end

	// one tick beat, with optional idle cycles ahead of it; valid stays high
	// into the next call so back-to-back ticks need no extra assignment
	task automatic send_tick(logic lvl);
		while (gaps_on && $urandom_range(0, 99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		pin_level <= lvl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_tick(lvl);
	endtask

	task automatic hold_level(logic lvl, int n);
		repeat (n) send_tick(lvl);
	endtask

	// register writes only go out with the core drained: every tick gives a
	// result, so an empty queue followed by a margin wait means idle
	task automatic write_reg(logic [bdslp_pkg::CFG_IDX_W-1:0] idx,
			logic [bdslp_pkg::CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.write_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	// Random phase: mostly clean runs long enough to settle the debouncer and
	// often to reach the hold time, with short bounces mixed in.
	task automatic random_phase(int deb, int lng, int quota);
		int   sent;
		int   len;
		logic lvl;
		sent = 0;
		lvl  = 1'b1;
		// upper data bits are junk; only the low 10 bits reach the debounce limit
		write_reg(bdslp_pkg::REG_DEBOUNCE, {6'($urandom_range(0, 63)), 10'(deb)});
		write_reg(bdslp_pkg::REG_LONG_PRESS, 16'(lng));
		while (sent < quota) begin
			if ($urandom_range(0, 99) < 80) begin
				lvl = ~lvl;
				len = $urandom_range(deb + 1, deb + lng + 4);
			end else begin
				lvl = 1'($urandom_range(0, 1));
				len = $urandom_range(1, deb + 1);
			end
			// keep runs short when the hold time is out of reach
			if (len > deb + 40)
				len = deb + 40;
			hold_level(lvl, len);
			sent += len;
		end
	endtask

	initial begin
		tracker = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset register values (debounce 50, hold 800) ---
		// pin pressed right out of reset: stable state must still start released
		hold_level(1'b0, 3);
		hold_level(1'b1, 55);
		// bounce shorter than the debounce time, no stable change
		hold_level(1'b0, 10);
		hold_level(1'b1, 10);
		// clean short press, then release gives the short pulse
		hold_level(1'b0, 60);
		hold_level(1'b1, 60);

		// --- zero debounce and zero hold time, with gaps ---
		gaps_on = 1'b1;
		write_reg(bdslp_pkg::REG_DEBOUNCE, 16'd0);
		write_reg(bdslp_pkg::REG_LONG_PRESS, 16'd0);
		// out-of-range indexes must not touch either register
		write_reg(REG_SPARE_A, 16'hFFFF);
		write_reg(REG_SPARE_B, 16'h5A5A);
		hold_level(1'b0, 1);
		hold_level(1'b1, 1);
		hold_level(1'b0, 3);
		hold_level(1'b1, 2);

		// --- random part, several register settings ---
		random_phase(0, 0, 100);
		random_phase(1, 1, 100);
		gaps_on = 1'b0;   // long stretch with no idling on either side
		random_phase(2, 6, 100);
		gaps_on = 1'b1;
		random_phase($urandom_range(0, 6), $urandom_range(0, 25), 100);
		random_phase($urandom_range(0, 6), $urandom_range(0, 25), 100);
		random_phase(5, 65535, 100);

		in_valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// hard stop, far past the slowest correct run
	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== button_debounce_short_long_press_core.f =====
rtl/core/bdslp_pkg.sv
rtl/core/button_debounce_short_long_press_core.sv
tb/button_debounce_short_long_press_core_test.sv
